@@ src/bmg_pkg.sv @@
`default_nettype none
package bmg_pkg;

    localparam int UNI_BITS = 32;
    localparam int RAD_LAT  = 66;
    localparam int COS_LAT  = 13;
    localparam int TRIG_DLY = RAD_LAT - COS_LAT;
    localparam int OUT_LAT  = RAD_LAT + 1;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // floor(x / k) = (x * ceil(2^38 / k)) >> 38, exact for x below 2^31
    localparam int RECIP_SH = 38;
    localparam logic [37:0] COS_RECIP [5] = '{
        38'(((64'd1 << 38) + 64'd89) / 64'd90),
        38'(((64'd1 << 38) + 64'd55) / 64'd56),
        38'(((64'd1 << 38) + 64'd29) / 64'd30),
        38'(((64'd1 << 38) + 64'd11) / 64'd12),
        38'(((64'd1 << 38) + 64'd1) / 64'd2)
    };
    localparam logic [37:0] SIN_RECIP [5] = '{
        38'(((64'd1 << 38) + 64'd109) / 64'd110),
        38'(((64'd1 << 38) + 64'd71) / 64'd72),
        38'(((64'd1 << 38) + 64'd41) / 64'd42),
        38'(((64'd1 << 38) + 64'd19) / 64'd20),
        38'(((64'd1 << 38) + 64'd5) / 64'd6)
    };

endpackage
`default_nettype wire

@@ src/bmg_radius.sv @@
`default_nettype none
module bmg_radius import bmg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_u,
    output logic      [30:0] o_radius
);

    logic [4:0]  n_p;
    logic [31:0] r_m [33];
    logic [31:0] r_f [33];
    logic [5:0]  r_e [33];
    logic [37:0] r_ell;
    logic [60:0] r_s;
    logic [60:0] r_sr [32];
    logic [60:0] r_rs [32];
    logic [61:0] n_prod;

    // top set bit of u
    always_comb begin
        n_p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_u[i]) begin
                n_p = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= i_u << (5'd31 - n_p);
            r_f[0] <= '0;
            r_e[0] <= 6'd32 - {1'b0, n_p};
        end
    end

    // one squaring per stage gives one bit of the log2 fraction
    for (genvar i = 0; i < 32; i++) begin : g_log
        logic [63:0] n_sq;
        logic [32:0] n_top;
        assign n_sq  = r_m[i] * r_m[i];
        assign n_top = n_sq[63:31];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[i+1] <= n_top[32] ? n_top[32:1] : n_top[31:0];
                r_f[i+1] <= r_f[i] | ({31'd0, n_top[32]} << (31 - i));
                r_e[i+1] <= r_e[i];
            end
        end
    end

    assign n_prod = r_ell[37:8] * LN2_Q32;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ell <= {r_e[32], 32'd0} - {6'd0, r_f[32]};
            r_s   <= n_prod[61:1];
        end
    end

    assign r_sr[0] = r_s;
    assign r_rs[0] = '0;

    // restoring square root, one result bit per stage
    for (genvar k = 0; k < 31; k++) begin : g_sqrt
        localparam logic [60:0] BIT = 61'd1 << (60 - 2 * k);
        logic [60:0] n_trial;
        assign n_trial = r_rs[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_sr[k] >= n_trial) begin
                    r_sr[k+1] <= r_sr[k] - n_trial;
                    r_rs[k+1] <= (r_rs[k] >> 1) + BIT;
                end else begin
                    r_sr[k+1] <= r_sr[k];
                    r_rs[k+1] <= r_rs[k] >> 1;
                end
            end
        end
    end

    assign o_radius = r_rs[31][30:0];

endmodule
`default_nettype wire

@@ src/bmg_cosine.sv @@
`default_nettype none
module bmg_cosine import bmg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_phase,
    output logic      [30:0] o_mag,
    output logic             o_neg
);

    logic [29:0] n_f;
    logic [61:0] n_fa;
    logic [29:0] r_a1;
    logic [2:0]  r_oct1;
    logic [59:0] n_sq;
    logic [29:0] r_ca   [11];
    logic [29:0] r_ca2  [9];
    logic [2:0]  r_coct [11];
    logic [30:0] r_tc  [6];
    logic [30:0] r_ts  [6];
    logic [30:0] r_xc  [5];
    logic [30:0] r_xs  [5];
    logic [60:0] n_sin;
    logic [2:0]  n_oct;

    // mirror in odd octants
    assign n_f  = i_phase[29] ? (30'h2000_0000 - {1'b0, i_phase[28:0]})
                              : {1'b0, i_phase[28:0]};
    assign n_fa = n_f * PI_Q30;
    assign n_sq = r_a1 * r_a1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a1      <= n_fa[60:31];
            r_oct1    <= i_phase[31:29];
            r_ca[0]   <= r_a1;
            r_ca2[0]  <= n_sq[59:30];
            r_coct[0] <= r_oct1;
        end
    end

    for (genvar h = 1; h < 11; h++) begin : g_carry
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ca[h]   <= r_ca[h-1];
                r_coct[h] <= r_coct[h-1];
            end
        end
    end

    for (genvar h = 1; h < 9; h++) begin : g_carry2
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ca2[h] <= r_ca2[h-1];
            end
        end
    end

    assign r_tc[0] = Q30_ONE;
    assign r_ts[0] = Q30_ONE;

    // horner steps: multiply by a^2, then divide by a constant
    for (genvar j = 0; j < 5; j++) begin : g_horner
        logic [60:0] n_pc;
        logic [60:0] n_ps;
        logic [68:0] n_qc;
        logic [68:0] n_qs;
        assign n_pc = r_ca2[2*j] * r_tc[j];
        assign n_ps = r_ca2[2*j] * r_ts[j];
        assign n_qc = r_xc[j] * COS_RECIP[j];
        assign n_qs = r_xs[j] * SIN_RECIP[j];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_xc[j]   <= n_pc[60:30];
                r_xs[j]   <= n_ps[60:30];
                r_tc[j+1] <= Q30_ONE - n_qc[68:RECIP_SH];
                r_ts[j+1] <= Q30_ONE - n_qs[68:RECIP_SH];
            end
        end
    end

    assign n_sin = r_ca[10] * r_ts[5];
    assign n_oct = r_coct[10];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_oct == 3'd0 || n_oct == 3'd3 || n_oct == 3'd4 || n_oct == 3'd7) begin
                o_mag <= r_tc[5];
            end else begin
                o_mag <= n_sin[60:30];
            end
            o_neg <= (n_oct >= 3'd2) && (n_oct <= 3'd5);
        end
    end

endmodule
`default_nettype wire

@@ src/box_muller_gaussian.sv @@
// box_muller_gaussian: one standard normal sample per input pair
// slave stream: s_axis_tdata holds u in the low 32 bits and v above it,
// both unsigned fractions of one; u must be nonzero
// master stream: m_axis_tdata is the sample, signed with 27 fractional
// bits; m_axis_tuser is set when u was zero and the sample then reads zero
// throughput: one transaction per clock, back to back, while the receiver does not stall
// the pipeline depth is set by the radius path
// (32 log squaring stages, two scale stages, 31 square root stages)
// the angle path (13 stages) runs in parallel and is delayed to match
// when the receiver stalls, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated
// reset clears all valid bits; data in flight is dropped
`default_nettype none
module box_muller_gaussian import bmg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // u_sample, v_sample
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // normal_value
    output logic             m_axis_tuser    // u_rejected
);

    logic        w_en;
    logic [OUT_LAT-1:0] r_vld;
    logic        r_rej  [RAD_LAT];
    logic [30:0] r_tmag [TRIG_DLY];
    logic        r_tneg [TRIG_DLY];
    logic [30:0] w_radius;
    logic [30:0] w_cmag;
    logic        w_cneg;
    logic [61:0] n_prod;
    logic [31:0] n_mag;

    assign w_en          = ~r_vld[OUT_LAT-1] | m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[OUT_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[OUT_LAT-2:0], s_axis_tvalid};
        end
    end

    bmg_radius u_radius (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_u      (s_axis_tdata[31:0]),
        .o_radius (w_radius)
    );

    bmg_cosine u_cosine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (s_axis_tdata[63:32]),
        .o_mag   (w_cmag),
        .o_neg   (w_cneg)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rej[0]  <= (s_axis_tdata[31:0] == 32'd0);
            r_tmag[0] <= w_cmag;
            r_tneg[0] <= w_cneg;
        end
    end

    for (genvar i = 1; i < RAD_LAT; i++) begin : g_rej
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rej[i] <= r_rej[i-1];
            end
        end
    end

    // angle result waits for the longer radius path
    for (genvar i = 1; i < TRIG_DLY; i++) begin : g_trig
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_tmag[i] <= r_tmag[i-1];
                r_tneg[i] <= r_tneg[i-1];
            end
        end
    end

    assign n_prod = w_radius * r_tmag[TRIG_DLY-1];
    assign n_mag  = n_prod[61:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tuser <= r_rej[RAD_LAT-1];
            if (r_rej[RAD_LAT-1]) begin
                m_axis_tdata <= '0;
            end else if (r_tneg[TRIG_DLY-1]) begin
                m_axis_tdata <= 32'd0 - n_mag;
            end else begin
                m_axis_tdata <= n_mag;
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/box_muller_gaussian_tb.sv @@
`timescale 1ns / 100ps
module box_muller_gaussian_tb import bmg_pkg::*;;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] value;
        logic        rejected;
    } t_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_sample expected_samples[$];
    int      mismatch_count = 0;
    int      sample_count = 0;
    int      reject_count = 0;
    int      idle_cycles = 0;
    logic    stall_enable = 1'b0;
    int      burst_left = 0;

    always #1 i_clk = ~i_clk;

    box_muller_gaussian u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // u_sample, v_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // normal_value
        .m_axis_tuser  (m_axis_tuser)     // u_rejected
    );

    // integer square root, digit by digit
    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bit_w;
        root = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > s) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (s >= root + bit_w) begin
                s = s - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    // sqrt(-2 ln u) in Q27
    function automatic logic [63:0] gauss_radius(input logic [31:0] u);
        logic [63:0] mant, frac, neg_log2, x;
        int top;
        x = {32'd0, u};
        top = 31;
        while (top > 0 && x[top] == 1'b0) top--;
        mant = x << (31 - top);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            mant = (mant * mant) >> 31;
            if (mant >= (64'd1 << 32)) begin
                mant = mant >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        neg_log2 = ({32'd0, 32'(UNI_BITS - top)} << 32) - frac;
        return int_sqrt(((neg_log2 >> 8) * 64'(LN2_Q32)) >> 1);
    endfunction

    // cos of a turn fraction, signed Q30
    function automatic logic signed [63:0] turn_cosine(input logic [31:0] phase);
        int unsigned cos_div[5] = '{90, 56, 30, 12, 2};
        int unsigned sin_div[5] = '{110, 72, 42, 20, 6};
        logic [2:0]  octant;
        logic [63:0] f, ang, ang2, tc, ts, mag;
        octant = phase[31:29];
        f = {35'd0, phase[28:0]};
        if (octant[0]) f = (64'd1 << 29) - f;
        ang = (f * 64'(PI_Q30)) >> 31;
        ang2 = (ang * ang) >> 30;
        tc = 64'(Q30_ONE);
        ts = 64'(Q30_ONE);
        for (int i = 0; i < 5; i++) begin
            tc = 64'(Q30_ONE) - ((ang2 * tc) >> 30) / cos_div[i];
            ts = 64'(Q30_ONE) - ((ang2 * ts) >> 30) / sin_div[i];
        end
        if (octant == 0 || octant == 3 || octant == 4 || octant == 7) mag = tc;
        else mag = (ang * ts) >> 30;
        if (octant >= 2 && octant <= 5) return -$signed(mag);
        return $signed(mag);
    endfunction

    function automatic t_sample predict_sample(input logic [31:0] u, input logic [31:0] v);
        t_sample res;
        logic signed [63:0] trig;
        logic [63:0] mag;
        if (u == 0) begin
            res.value = '0;
            res.rejected = 1'b1;
            return res;
        end
        trig = turn_cosine(v);
        mag = (gauss_radius(u) * (trig < 0 ? -trig : trig)) >> 30;
        if (trig < 0) mag = -mag;
        res.value = mag[31:0];
        res.rejected = 1'b0;
        return res;
    endfunction

    // one transaction on the input side, with bursty gaps
    task automatic send_pair(input logic [31:0] u, input logic [31:0] v);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v, u};
        expected_samples.insert(expected_samples.size(), predict_sample(u, v));
        sample_count++;
        if (u == 0) reject_count++;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!stall_enable) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: value %h rejected %b",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_samples.pop_front();
                if (want.value !== m_axis_tdata || want.rejected !== m_axis_tuser) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b actual %h/%b",
                                 want.value, want.rejected, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || expected_samples.size() == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed_extremes();
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'hFFFF_FFFF);
        send_pair(32'd1, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'd1, 32'h4000_0000);
        for (int k = 0; k < 8; k++) begin
            send_pair(32'h0000_1234 << k, {3'(k), 29'd0});
            send_pair(32'h7FFF_FFFF, {3'(k), 29'h1FFF_FFFF});
        end
    endtask

    task automatic test_back_to_back();
        stall_enable = 1'b0;
        burst_left = 200;
        for (int k = 0; k < 150; k++) send_pair($urandom, $urandom);
        drain_pipeline();
    endtask

    task automatic test_random_stalls();
        logic [31:0] u;
        stall_enable = 1'b1;
        burst_left = 0;
        for (int k = 0; k < 750; k++) begin
            case ($urandom_range(0, 9))
                0:       u = 32'd0;
                1:       u = 32'd1 << $urandom_range(0, 31);
                2:       u = $urandom >> $urandom_range(0, 31);
                default: u = $urandom;
            endcase
            send_pair(u, $urandom);
            if (k == 400) drain_pipeline();
        end
        drain_pipeline();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        drain_pipeline();
        test_back_to_back();
        test_random_stalls();
        repeat (OUT_LAT + 10) @(posedge i_clk);
        $display("covered %0d samples, %0d with zero u, under bursty input and output stalls",
                 sample_count, reject_count);
        if (mismatch_count == 0 && expected_samples.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end
endmodule
